[rtl/ccr_pkg.sv]
// Shared types and constants for the circumcircle radius pipeline.
// No dependencies; every other file in rtl/ imports this package.
package ccr_pkg;

    // Coordinate and result formats (10 fraction bits throughout).
    localparam int COORD_WIDTH = 24;
    localparam int OUT_WIDTH   = 40;

    // Widths of the exact integer intermediates.
    localparam int DIFF_W = COORD_WIDTH + 1;          // point differences
    localparam int PROD_W = 2 * DIFF_W;               // difference products
    localparam int DET_W  = PROD_W + 1;               // determinant D
    localparam int T_W    = PROD_W;                   // squared distances (unsigned)
    localparam int TL_W   = DIFF_W;                   // low slice of a squared distance
    localparam int TH_W   = T_W - TL_W;               // high slice of a squared distance
    localparam int PP_W   = DIFF_W + TH_W + 1;        // slice-by-difference products
    localparam int TV_W   = T_W + DIFF_W + 1;         // distance-by-difference products
    localparam int DL_W   = DIFF_W + 1;               // low slice of D
    localparam int DX_W   = DET_W + COORD_WIDTH;      // D times a coordinate
    localparam int A_W    = TV_W + 1;                 // center numerators relative to point 3
    localparam int P_W    = A_W + 1;                  // absolute center numerators

    // Limb squarer.
    localparam int LIMB_W    = (A_W + 1) / 3;
    localparam int SQR_IN_W  = 3 * LIMB_W;
    localparam int SQR_OUT_W = 2 * SQR_IN_W;
    localparam int SQR_LAT   = 3;

    // Square root and divider.
    localparam int ROOT_W  = A_W;
    localparam int SQ_W    = 2 * ROOT_W;
    localparam int QUO_W   = OUT_WIDTH + 2;
    localparam int NUM_W   = P_W;
    localparam int DEN_W   = DET_W + 2;
    localparam int CMP_W   = DEN_W + QUO_W;
    localparam int DIV_LAT = QUO_W + 1;

    // Delay that lines the center path up with the square root path.
    localparam int ALIGN_DLY = SQR_LAT + ROOT_W - 1;
    localparam int LAT       = 9 + ALIGN_DLY + DIV_LAT + 1;

    // Status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_COLLINEAR = 2'd1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_first;
        logic signed [COORD_WIDTH-1:0] y_first;
        logic signed [COORD_WIDTH-1:0] x_second;
        logic signed [COORD_WIDTH-1:0] y_second;
        logic signed [COORD_WIDTH-1:0] x_third;
        logic signed [COORD_WIDTH-1:0] y_third;
    } in_beat_t;

    typedef struct packed {
        logic        [OUT_WIDTH-1:0] radius;
        logic signed [OUT_WIDTH-1:0] coef_g;
        logic signed [OUT_WIDTH-1:0] coef_f;
        logic        [1:0]           status;
    } out_beat_t;

    // Divider operands that wait for the square root to finish.
    typedef struct packed {
        logic [NUM_W-1:0] num_g;
        logic [NUM_W-1:0] num_f;
        logic [DEN_W-1:0] den_gf;
        logic [DEN_W-1:0] den_r;
        logic             neg_g;
        logic             neg_f;
        logic             collinear;
    } align_t;

endpackage

[rtl/ccr_sqr.sv]
// Pipelined squarer for wide unsigned values, built from three limbs.
// Depends on ccr_pkg for the limb and result widths.
module ccr_sqr import ccr_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [SQR_IN_W-1:0]  din,
    output logic [SQR_OUT_W-1:0] dout
);

    localparam int LP_W = 2 * LIMB_W;
    localparam int X_W  = 5 * LIMB_W;

    logic [LIMB_W-1:0]    a0, a1, a2;
    logic [LP_W-1:0]      p00_reg, p11_reg, p22_reg, p01_reg, p02_reg, p12_reg;
    logic [SQR_OUT_W-1:0] diag_reg;
    logic [X_W-1:0]       cross_reg;
    logic [SQR_OUT_W-1:0] dout_reg;

    assign a0 = din[LIMB_W-1:0];
    assign a1 = din[2*LIMB_W-1:LIMB_W];
    assign a2 = din[3*LIMB_W-1:2*LIMB_W];

    // Limb products; each cross product appears twice in the square.
    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg <= LP_W'(a0) * LP_W'(a0);
            p11_reg <= LP_W'(a1) * LP_W'(a1);
            p22_reg <= LP_W'(a2) * LP_W'(a2);
            p01_reg <= LP_W'(a0) * LP_W'(a1);
            p02_reg <= LP_W'(a0) * LP_W'(a2);
            p12_reg <= LP_W'(a1) * LP_W'(a2);
        end
    end

    // Diagonal terms do not overlap, so they concatenate; the cross terms need one add.
    always_ff @(posedge aclk) begin
        if (en) begin
            diag_reg  <= {p22_reg, p11_reg, p00_reg};
            cross_reg <= (X_W'({p12_reg, p01_reg}) << LIMB_W) + (X_W'(p02_reg) << (2 * LIMB_W));
        end
    end

    // Final sum with the doubled cross terms.
    always_ff @(posedge aclk) begin
        if (en) begin
            dout_reg <= diag_reg + (SQR_OUT_W'(cross_reg) << 1);
        end
    end

    assign dout = dout_reg;

endmodule

[rtl/ccr_sqrt.sv]
// Pipelined integer square root, one result bit per stage (floor of the root).
// Depends on ccr_pkg for the operand and root widths.
module ccr_sqrt import ccr_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [SQ_W-1:0]   din,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W-1:0]   rem_reg  [0:ROOT_W-2];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];

    // Stage k decides root bit ROOT_W-1-k against the remaining radicand.
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   trial;
        logic              fits;

        if (k == 0) begin : g_first
            assign rem_in  = din;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        assign trial = (SQ_W'(root_in) << (B + 1)) | (SQ_W'(1) << (2 * B));
        assign fits  = rem_in >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= fits ? (root_in | (ROOT_W'(1) << B)) : root_in;
            end
        end

        if (k < ROOT_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= fits ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

[rtl/ccr_div.sv]
// Pipelined restoring divider with a limited quotient and an overflow flag.
// Depends on ccr_pkg for the numerator, denominator and quotient widths.
module ccr_div import ccr_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             tag_in,
    output logic [QUO_W-1:0] quo,
    output logic             ovf,
    output logic             tag_out
);

    logic [NUM_W-1:0] rem_reg [0:QUO_W-1];
    logic [DEN_W-1:0] den_reg [0:QUO_W-1];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic             ovf_reg [0:QUO_W];
    logic             tag_reg [0:QUO_W];

    // Entry stage: flag quotients that do not fit in QUO_W bits.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            ovf_reg[0] <= CMP_W'(num) >= (CMP_W'(den) << QUO_W);
            tag_reg[0] <= tag_in;
        end
    end

    // Stage k settles quotient bit QUO_W-k with one compare and subtract.
    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - k;
        logic [CMP_W-1:0] shifted;
        logic [CMP_W-1:0] rem_ext;
        logic             fits;

        assign shifted = CMP_W'(den_reg[k-1]) << B;
        assign rem_ext = CMP_W'(rem_reg[k-1]);
        assign fits    = rem_ext >= shifted;

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k] <= fits ? (quo_reg[k-1] | (QUO_W'(1) << B)) : quo_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end

        if (k < QUO_W) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= fits ? NUM_W'(rem_ext - shifted) : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo     = quo_reg[QUO_W];
    assign ovf     = ovf_reg[QUO_W];
    assign tag_out = tag_reg[QUO_W];

endmodule

[rtl/circumcircle_radius_three_points.sv]
// Circumcircle of three points: one result beat for each input beat, in order.
// Throughput is one beat per cycle; the whole pipeline advances together and holds
// while a result beat waits on m_ready. The depth is set by the 77-stage square
// root and the 43-stage dividers. Reset (aresetn low, synchronous) clears only the
// valid bits, so the pipeline comes up empty; data registers are not reset.
module circumcircle_radius_three_points import ccr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic adv;
    logic [LAT-1:0] vld_reg;

    // Stage 1: coordinates relative to the third point.
    logic signed [DIFF_W-1:0]      u1_reg, v1_reg, u2_reg, v2_reg;
    logic signed [COORD_WIDTH-1:0] x3_1_reg, y3_1_reg;
    // Stage 2: difference products.
    logic signed [PROD_W-1:0]      pa_reg, pb_reg, su1_reg, sv1_reg, su2_reg, sv2_reg;
    logic signed [DIFF_W-1:0]      u1_2_reg, v1_2_reg, u2_2_reg, v2_2_reg;
    logic signed [COORD_WIDTH-1:0] x3_2_reg, y3_2_reg;
    // Stage 3: determinant and squared distances.
    logic signed [DET_W-1:0]       d_3_reg;
    logic        [T_W-1:0]         t1_reg, t2_reg;
    logic signed [DIFF_W-1:0]      u1_3_reg, v1_3_reg, u2_3_reg, v2_3_reg;
    logic signed [COORD_WIDTH-1:0] x3_3_reg, y3_3_reg;
    // Stage 4: sliced partial products.
    logic signed [PP_W-1:0]        tv21h_reg, tv21l_reg, tv12h_reg, tv12l_reg;
    logic signed [PP_W-1:0]        tu21h_reg, tu21l_reg, tu12h_reg, tu12l_reg;
    logic signed [DX_W-1:0]        dxh_reg, dxl_reg, dyh_reg, dyl_reg;
    logic signed [DET_W-1:0]       d_4_reg;
    // Stage 5: full products.
    logic signed [TV_W-1:0]        tv21_reg, tv12_reg, tu21_reg, tu12_reg;
    logic signed [DX_W-1:0]        dx_5_reg, dy_5_reg;
    logic signed [DET_W-1:0]       d_5_reg;
    // Stage 6: center numerators relative to the third point.
    logic signed [A_W-1:0]         a_reg, b_reg;
    logic signed [DX_W-1:0]        dx_6_reg, dy_6_reg;
    logic signed [DET_W-1:0]       d_6_reg;
    // Stage 7: absolute center numerators and magnitudes for the radius.
    logic signed [P_W-1:0]         p_reg, q_reg;
    logic        [A_W-1:0]         absa_reg, absb_reg;
    logic signed [DET_W-1:0]       d_7_reg;
    // Stage 8: magnitudes and signs for the center divisions.
    logic        [P_W-1:0]         absp_reg, absq_reg;
    logic        [DET_W-1:0]       absd_reg;
    logic                          negg_8_reg, negf_8_reg, dz_8_reg;
    // Stage 9: divider operands.
    align_t                        al_9_reg;
    align_t                        dly_reg [0:ALIGN_DLY-1];
    align_t                        al_out;

    // Radius path.
    logic [SQR_OUT_W-1:0] sqa, sqb;
    logic [SQ_W-1:0]      n_reg;
    logic [ROOT_W-1:0]    root;

    // Divider results.
    logic [QUO_W-1:0] quo_g, quo_f, quo_r;
    logic             ovf_g, ovf_f, ovf_r;
    logic             neg_g, neg_f, collinear;

    out_beat_t m_data_reg;
    out_beat_t res;

    // The whole pipeline moves when the output register is empty or being drained.
    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];
    assign m_data  = m_data_reg;

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Stage 1: shift the frame so that the third point is the origin.
    always_ff @(posedge aclk) begin
        if (adv) begin
            u1_reg   <= DIFF_W'(s_data.x_first)  - DIFF_W'(s_data.x_third);
            v1_reg   <= DIFF_W'(s_data.y_first)  - DIFF_W'(s_data.y_third);
            u2_reg   <= DIFF_W'(s_data.x_second) - DIFF_W'(s_data.x_third);
            v2_reg   <= DIFF_W'(s_data.y_second) - DIFF_W'(s_data.y_third);
            x3_1_reg <= s_data.x_third;
            y3_1_reg <= s_data.y_third;
        end
    end

    // Stage 2: cross products for the determinant and the squared distances.
    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_reg   <= PROD_W'(v1_reg) * PROD_W'(u2_reg);
            pb_reg   <= PROD_W'(u1_reg) * PROD_W'(v2_reg);
            su1_reg  <= PROD_W'(u1_reg) * PROD_W'(u1_reg);
            sv1_reg  <= PROD_W'(v1_reg) * PROD_W'(v1_reg);
            su2_reg  <= PROD_W'(u2_reg) * PROD_W'(u2_reg);
            sv2_reg  <= PROD_W'(v2_reg) * PROD_W'(v2_reg);
            u1_2_reg <= u1_reg;
            v1_2_reg <= v1_reg;
            u2_2_reg <= u2_reg;
            v2_2_reg <= v2_reg;
            x3_2_reg <= x3_1_reg;
            y3_2_reg <= y3_1_reg;
        end
    end

    // Stage 3: determinant and squared distances to the third point.
    always_ff @(posedge aclk) begin
        if (adv) begin
            d_3_reg  <= DET_W'(pa_reg) - DET_W'(pb_reg);
            t1_reg   <= T_W'(su1_reg + sv1_reg);
            t2_reg   <= T_W'(su2_reg + sv2_reg);
            u1_3_reg <= u1_2_reg;
            v1_3_reg <= v1_2_reg;
            u2_3_reg <= u2_2_reg;
            v2_3_reg <= v2_2_reg;
            x3_3_reg <= x3_2_reg;
            y3_3_reg <= y3_2_reg;
        end
    end

    // Stage 4: wide products split into two narrow slices each.
    always_ff @(posedge aclk) begin
        if (adv) begin
            tv21h_reg <= PP_W'($signed({1'b0, t2_reg[T_W-1:TL_W]})) * PP_W'(v1_3_reg);
            tv21l_reg <= PP_W'($signed({1'b0, t2_reg[TL_W-1:0]}))   * PP_W'(v1_3_reg);
            tv12h_reg <= PP_W'($signed({1'b0, t1_reg[T_W-1:TL_W]})) * PP_W'(v2_3_reg);
            tv12l_reg <= PP_W'($signed({1'b0, t1_reg[TL_W-1:0]}))   * PP_W'(v2_3_reg);
            tu21h_reg <= PP_W'($signed({1'b0, t2_reg[T_W-1:TL_W]})) * PP_W'(u1_3_reg);
            tu21l_reg <= PP_W'($signed({1'b0, t2_reg[TL_W-1:0]}))   * PP_W'(u1_3_reg);
            tu12h_reg <= PP_W'($signed({1'b0, t1_reg[T_W-1:TL_W]})) * PP_W'(u2_3_reg);
            tu12l_reg <= PP_W'($signed({1'b0, t1_reg[TL_W-1:0]}))   * PP_W'(u2_3_reg);
            dxh_reg   <= DX_W'($signed(d_3_reg[DET_W-1:DL_W]))     * DX_W'(x3_3_reg);
            dxl_reg   <= DX_W'($signed({1'b0, d_3_reg[DL_W-1:0]})) * DX_W'(x3_3_reg);
            dyh_reg   <= DX_W'($signed(d_3_reg[DET_W-1:DL_W]))     * DX_W'(y3_3_reg);
            dyl_reg   <= DX_W'($signed({1'b0, d_3_reg[DL_W-1:0]})) * DX_W'(y3_3_reg);
            d_4_reg   <= d_3_reg;
        end
    end

    // Stage 5: recombine the slices.
    always_ff @(posedge aclk) begin
        if (adv) begin
            tv21_reg <= (TV_W'(tv21h_reg) <<< TL_W) + TV_W'(tv21l_reg);
            tv12_reg <= (TV_W'(tv12h_reg) <<< TL_W) + TV_W'(tv12l_reg);
            tu21_reg <= (TV_W'(tu21h_reg) <<< TL_W) + TV_W'(tu21l_reg);
            tu12_reg <= (TV_W'(tu12h_reg) <<< TL_W) + TV_W'(tu12l_reg);
            dx_5_reg <= (dxh_reg <<< DL_W) + dxl_reg;
            dy_5_reg <= (dyh_reg <<< DL_W) + dyl_reg;
            d_5_reg  <= d_4_reg;
        end
    end

    // Stage 6: the center relative to the third point is (A, B) / (2D).
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg    <= A_W'(tv21_reg) - A_W'(tv12_reg);
            b_reg    <= A_W'(tu12_reg) - A_W'(tu21_reg);
            dx_6_reg <= dx_5_reg;
            dy_6_reg <= dy_5_reg;
            d_6_reg  <= d_5_reg;
        end
    end

    // Stage 7: absolute center is (P, Q) / (2D); twice the radius is |(A, B)| / |D|.
    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg    <= (P_W'(dx_6_reg) <<< 1) + P_W'(a_reg);
            q_reg    <= (P_W'(dy_6_reg) <<< 1) + P_W'(b_reg);
            absa_reg <= a_reg[A_W-1] ? A_W'(-a_reg) : A_W'(a_reg);
            absb_reg <= b_reg[A_W-1] ? A_W'(-b_reg) : A_W'(b_reg);
            d_7_reg  <= d_6_reg;
        end
    end

    // Stage 8: g = -P / (4D) and f = -Q / (4D), divided as magnitudes.
    always_ff @(posedge aclk) begin
        if (adv) begin
            absp_reg   <= p_reg[P_W-1] ? P_W'(-p_reg) : P_W'(p_reg);
            absq_reg   <= q_reg[P_W-1] ? P_W'(-q_reg) : P_W'(q_reg);
            absd_reg   <= d_7_reg[DET_W-1] ? DET_W'(-d_7_reg) : DET_W'(d_7_reg);
            negg_8_reg <= (!p_reg[P_W-1] && (p_reg != '0)) != d_7_reg[DET_W-1];
            negf_8_reg <= (!q_reg[P_W-1] && (q_reg != '0)) != d_7_reg[DET_W-1];
            dz_8_reg   <= d_7_reg == '0;
        end
    end

    // Stage 9: rounding to nearest is floor((|n| + |2D|) / |4D|).
    always_ff @(posedge aclk) begin
        if (adv) begin
            al_9_reg.num_g     <= absp_reg + (NUM_W'(absd_reg) << 1);
            al_9_reg.num_f     <= absq_reg + (NUM_W'(absd_reg) << 1);
            al_9_reg.den_gf    <= DEN_W'(absd_reg) << 2;
            al_9_reg.den_r     <= DEN_W'(absd_reg);
            al_9_reg.neg_g     <= negg_8_reg;
            al_9_reg.neg_f     <= negf_8_reg;
            al_9_reg.collinear <= dz_8_reg;
        end
    end

    // Divider operands wait here while the radius goes through the square root.
    always_ff @(posedge aclk) begin
        if (adv) begin
            dly_reg[0] <= al_9_reg;
            for (int i = 1; i < ALIGN_DLY; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign al_out = dly_reg[ALIGN_DLY-1];

    // Radius path: square both numerators, add, take the root.
    ccr_sqr u_sqr_a (
        .aclk (aclk),
        .en   (adv),
        .din  (SQR_IN_W'(absa_reg)),
        .dout (sqa)
    );

    ccr_sqr u_sqr_b (
        .aclk (aclk),
        .en   (adv),
        .din  (SQR_IN_W'(absb_reg)),
        .dout (sqb)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            n_reg <= SQ_W'(sqa) + SQ_W'(sqb);
        end
    end

    ccr_sqrt u_sqrt (
        .aclk (aclk),
        .en   (adv),
        .din  (n_reg),
        .root (root)
    );

    // Three dividers run side by side.
    ccr_div u_div_g (
        .aclk    (aclk),
        .en      (adv),
        .num     (al_out.num_g),
        .den     (al_out.den_gf),
        .tag_in  (al_out.neg_g),
        .quo     (quo_g),
        .ovf     (ovf_g),
        .tag_out (neg_g)
    );

    ccr_div u_div_f (
        .aclk    (aclk),
        .en      (adv),
        .num     (al_out.num_f),
        .den     (al_out.den_gf),
        .tag_in  (al_out.neg_f),
        .quo     (quo_f),
        .ovf     (ovf_f),
        .tag_out (neg_f)
    );

    ccr_div u_div_r (
        .aclk    (aclk),
        .en      (adv),
        .num     (NUM_W'(root)),
        .den     (al_out.den_r),
        .tag_in  (al_out.collinear),
        .quo     (quo_r),
        .ovf     (ovf_r),
        .tag_out (collinear)
    );

    // Apply the sign and clamp a coefficient to the signed output range.
    function automatic logic [OUT_WIDTH-1:0] coef_sat(
        input logic [QUO_W-1:0] mag,
        input logic             over,
        input logic             neg
    );
        logic [QUO_W-1:0] lim;
        logic [QUO_W-1:0] m;
        lim = QUO_W'(1) << (OUT_WIDTH - 1);
        if (neg) begin
            m = (over || (mag > lim)) ? lim : mag;
            return OUT_WIDTH'(-m);
        end else begin
            m = (over || (mag > (lim - QUO_W'(1)))) ? (lim - QUO_W'(1)) : mag;
            return OUT_WIDTH'(m);
        end
    endfunction

    // Twice the radius, halved with ties rounded up, then clamped.
    function automatic logic [OUT_WIDTH-1:0] radius_sat(
        input logic [QUO_W-1:0] twice,
        input logic             over
    );
        logic [QUO_W:0] rnd;
        logic [QUO_W:0] rmax;
        rnd  = ({1'b0, twice} + (QUO_W + 1)'(1)) >> 1;
        rmax = (QUO_W + 1)'({OUT_WIDTH{1'b1}});
        if (over || (rnd > rmax)) begin
            return OUT_WIDTH'(rmax);
        end else begin
            return OUT_WIDTH'(rnd);
        end
    endfunction

    // Collinear points give zeros and their own status.
    always_comb begin
        if (collinear) begin
            res.radius = '0;
            res.coef_g = '0;
            res.coef_f = '0;
            res.status = STATUS_COLLINEAR;
        end else begin
            res.radius = radius_sat(quo_r, ovf_r);
            res.coef_g = coef_sat(quo_g, ovf_g, neg_g);
            res.coef_f = coef_sat(quo_f, ovf_f, neg_f);
            res.status = STATUS_OK;
        end
    end

    // Output register: holds the result beat until it is taken.
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= res;
        end
    end

endmodule

[bench/tb_circumcircle_radius_three_points.sv]
// Self-checking testbench for circumcircle_radius_three_points: random and directed
// point triplets, with exact wide-integer prediction of g, f, radius and status.
// Depends on ccr_pkg and the circumcircle_radius_three_points RTL.
`timescale 1ns / 1ps

module tb_circumcircle_radius_three_points;
    import ccr_pkg::*;

    typedef logic signed [255:0] wide_t;
    typedef logic        [255:0] uwide_t;

    localparam int N_RANDOM   = 1200;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD  = 600;

    // Rounds n/(2*dv) to nearest, ties away from zero, saturated to a signed result field.
    function automatic logic [OUT_WIDTH-1:0] round_quotient(wide_t n, wide_t dv);
        logic   neg;
        uwide_t an, ad, mag, lim;
        neg = (n < 0) != (dv < 0);
        an  = (n < 0) ? uwide_t'(-n) : uwide_t'(n);
        ad  = (dv < 0) ? uwide_t'(-dv) : uwide_t'(dv);
        mag = (an + ad) / (ad + ad);
        lim = uwide_t'(1) << (OUT_WIDTH - 1);
        if (mag == 0) return '0;
        if (neg) begin
            if (mag > lim) mag = lim;
            return OUT_WIDTH'(-mag);
        end
        if (mag > lim - 1) mag = lim - 1;
        return OUT_WIDTH'(mag);
    endfunction

    // Exact circumcircle of one triplet.
    function automatic out_beat_t circle_of(in_beat_t b);
        wide_t     x1, y1, x2, y2, x3, y3, det, s1, s2, s3, pn, qn, ra, rb;
        uwide_t    sq, quo, root, cand, rad;
        out_beat_t r;
        x1 = b.x_first;  y1 = b.y_first;
        x2 = b.x_second; y2 = b.y_second;
        x3 = b.x_third;  y3 = b.y_third;
        det = (y1 - y3) * (x2 - x3) - (x1 - x3) * (y2 - y3);
        r = '0;
        if (det == 0) begin
            r.status = STATUS_COLLINEAR;
            return r;
        end
        s1 = x1 * x1 + y1 * y1;
        s2 = x2 * x2 + y2 * y2;
        s3 = x3 * x3 + y3 * y3;
        pn = (y3 - y2) * s1 + (y1 - y3) * s2 + (y2 - y1) * s3;
        qn = (x2 - x3) * s1 + (x3 - x1) * s2 + (x1 - x2) * s3;
        ra = 2 * det * x1 - pn;
        rb = 2 * det * y1 - qn;
        sq = uwide_t'(ra * ra + rb * rb);
        quo = sq / uwide_t'(det * det);
        root = '0;
        for (int i = 127; i >= 0; i--) begin
            cand = root | (uwide_t'(1) << i);
            if (cand * cand <= quo) root = cand;
        end
        rad = (root + 1) >> 1;
        if (rad > (uwide_t'(1) << OUT_WIDTH) - 1) rad = (uwide_t'(1) << OUT_WIDTH) - 1;
        r.radius = OUT_WIDTH'(rad);
        r.coef_g = round_quotient(-pn, 2 * det);
        r.coef_f = round_quotient(-qn, 2 * det);
        r.status = STATUS_OK;
        return r;
    endfunction

    // Holds the expected circles in order and compares each result beat.
    class circle_scoreboard;
        out_beat_t pending[$];
        int        errors;

        function void note_input(in_beat_t b);
            pending.insert(pending.size(), circle_of(b));
        endfunction

        task report(string what, logic [OUT_WIDTH-1:0] got, logic [OUT_WIDTH-1:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_result(out_beat_t got);
            out_beat_t want;
            if (pending.size() == 0) begin
                report("unexpected beat", got.radius, '0);
                return;
            end
            want = pending.pop_front();
            if (got.radius !== want.radius) report("radius", got.radius, want.radius);
            if (got.coef_g !== want.coef_g) report("coef_g", got.coef_g, want.coef_g);
            if (got.coef_f !== want.coef_f) report("coef_f", got.coef_f, want.coef_f);
            if (got.status !== want.status) begin
                report("status", OUT_WIDTH'(got.status), OUT_WIDTH'(want.status));
            end
        endtask
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    circle_scoreboard sb;
    int  hold_request;
    int  idle_cycles;

    circumcircle_radius_three_points uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: check every beat taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: changes stall mode now and then; a requested long hold-off overrides it.
    initial begin
        int mode, left, hold;
        bit hold_done;
        mode = 0; left = 0; hold = 0;
        hold_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if ((hold_request > 0) && !hold_done) begin
                hold = hold_request;
                hold_done = 1'b1;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 9) < 7);
                    2: m_ready <= ($urandom_range(0, 9) < 3);
                    default: m_ready <= (left % 8) < 5;
                endcase
            end
        end
    end

    // Offers one beat and waits until it is taken; the caller lowers valid if needed.
    task automatic send_points(in_beat_t b);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(b);
        @(negedge aclk);
    endtask

    task automatic idle_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] any_coord();
        return COORD_WIDTH'($urandom());
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] near_coord(int span);
        return COORD_WIDTH'($urandom_range(0, 2 * span) - span);
    endfunction

    // Random triplet: full range, small values, or collinear by construction.
    function automatic in_beat_t random_triplet();
        in_beat_t b;
        int       kind, span, k;
        kind = $urandom_range(0, 9);
        span = (kind < 5) ? 4096 : 1 << $urandom_range(2, 22);
        if (kind < 3) begin
            b = {any_coord(), any_coord(), any_coord(), any_coord(), any_coord(), any_coord()};
        end else begin
            b = {near_coord(span), near_coord(span), near_coord(span),
                 near_coord(span), near_coord(span), near_coord(span)};
        end
        if (kind == 9) begin
            k = $urandom_range(0, 4) - 2;
            b.x_second = b.x_first + near_coord(64);
            b.y_second = b.y_first + near_coord(64);
            b.x_third  = b.x_first + k * (b.x_second - b.x_first);
            b.y_third  = b.y_first + k * (b.y_second - b.y_first);
        end
        return b;
    endfunction

    initial begin
        localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        localparam logic signed [COORD_WIDTH-1:0] ONE  = 1024;
        in_beat_t directed[$];
        int       burst;
        sb = new();
        hold_request = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Repeated and collinear points, unit circles, extremes and rounding ties.
        directed = '{
            '{0, 0, 0, 0, 0, 0},
            '{ONE, ONE, ONE, ONE, 5, 7},
            '{0, 0, ONE, ONE, 2 * ONE, 2 * ONE},
            '{ONE, 0, 0, ONE, -ONE, 0},
            '{ONE, 0, -ONE, 0, 0, -ONE},
            '{1, 0, 0, 1, -1, 0},
            '{1, 0, 0, 0, 0, 1},
            '{3, 0, 0, 0, 0, 1},
            '{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN},
            '{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX},
            '{CMAX, 0, CMIN, 0, 0, CMAX},
            '{CMAX, CMAX, CMAX, CMAX - 1, CMAX - 1, CMAX},
            '{CMIN, CMIN, CMIN + 1, CMIN, CMIN, CMIN + 1},
            '{0, 0, 1, 0, CMAX, 1},
            '{0, 0, 1, 1, CMAX, CMAX - 1},
            '{CMIN, CMAX, CMAX, CMIN, 0, 0},
            '{-1, -1, -1, -1, -1, -1},
            '{5, -3, -7, 2, 11, 13},
            '{CMAX, CMIN, CMIN, CMAX, CMAX, CMAX}
        };
        foreach (directed[i]) send_points(directed[i]);

        // Random stream in bursts; one long receiver hold-off and one drain pause.
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) hold_request = LONG_HOLD;
            if (n == 700) begin
                s_valid <= 1'b0;
                while (sb.pending.size() != 0) @(negedge aclk);
            end
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
            end
            burst--;
            send_points(random_triplet());
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LAT + 10) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
